// ----- sv/mat_pkg.sv -----
// Shared types and constants for the multi-turn angle tracker.
// Holds widths, fixed-point constants, the controller state type and the
// command and status structs used between controller and datapath.
`default_nettype none

package mat_pkg;

  // Field and register widths.
  localparam int COUNT_BITS    = 12;
  localparam int TURN_BITS     = 16;
  localparam int FRAC_BITS     = 16;
  localparam int WORD_BITS     = 16;
  localparam int CPR_BITS      = 13;
  localparam int POLE_BITS     = 7;
  localparam int OFFSET_BITS   = 19;
  localparam int MECH_BITS     = 35;
  localparam int ELEC_BITS     = 19;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 19;

  // Datapath widths.
  localparam int NUM_BITS  = CPR_BITS + 1 + TURN_BITS;   // count + cpr * turns, signed
  localparam int MAG_BITS  = 28;                         // magnitude of that sum
  localparam int PPC_BITS  = POLE_BITS + COUNT_BITS;     // pole_pairs * count
  localparam int KLO_BITS  = 18;
  localparam int KHI_BITS  = 17;
  localparam int PROD_BITS = MAG_BITS + KLO_BITS;
  localparam int ACC_BITS  = 64;
  localparam int DVD_BITS  = 48;
  localparam int QUO_BITS  = 34;
  localparam int CNT_BITS  = 5;

  // Quotient widths of the three divisions, two bits per step.
  localparam int QW_MOD  = 20;
  localparam int QW_ELEC = 20;
  localparam int QW_MECH = 34;

  // 2*pi scaled by 2^32, split for the narrow multiplier, and 2*pi in Q.16.
  localparam logic [34:0] PI2_Q32 = 35'd26986075409;
  localparam logic [KLO_BITS-1:0] PI2_K_LO = PI2_Q32[KLO_BITS-1:0];
  localparam logic [KHI_BITS-1:0] PI2_K_HI = PI2_Q32[34:KLO_BITS];
  localparam logic [ELEC_BITS-1:0] PI2_QF = 19'd411775;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CPR    = 2'd0,
    CFG_POLE   = 2'd1,
    CFG_OFFSET = 2'd2
  } cfg_idx_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_TURN,
    S_PROD,
    S_MOD_LD,
    S_MOD_RUN,
    S_EMUL_LO,
    S_EMUL_HI,
    S_EDIV_LD,
    S_EDIV_RUN,
    S_ELEC_FIN,
    S_MMUL_LO,
    S_MMUL_HI,
    S_MDIV_LD,
    S_MDIV_RUN,
    S_DONE
  } state_t;

  // Which division the shared divider is loaded for.
  typedef enum logic [1:0] {
    DSEL_MOD,
    DSEL_ELEC,
    DSEL_MECH
  } dsel_t;

  // Which operand feeds the multiplier.
  typedef enum logic {
    MSRC_ELEC,
    MSRC_MECH
  } msrc_t;

  typedef struct packed {
    logic  capture;
    logic  turn;
    logic  prod;
    logic  div_load;
    dsel_t div_sel;
    logic  div_step;
    logic  mul_lo;
    logic  mul_hi;
    msrc_t mul_src;
    logic  elec_fin;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- sv/mat_if.sv -----
// Valid/ready channel interfaces for the multi-turn angle tracker.
// Depends on mat_pkg for the payload widths.
`default_nettype none

interface mat_in_if;
  import mat_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [WORD_BITS-1:0] spi_word;

  modport source (output valid, kind, spi_word, input ready);
  modport sink   (input valid, kind, spi_word, output ready);
endinterface

interface mat_out_if;
  import mat_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [MECH_BITS-1:0] mech_angle;
  logic [ELEC_BITS-1:0]        elec_angle;
  logic signed [TURN_BITS-1:0] turns;

  modport source (output valid, mech_angle, elec_angle, turns, input ready);
  modport sink   (input valid, mech_angle, elec_angle, turns, output ready);
endinterface

`default_nettype wire

// ----- sv/mat_ctrl.sv -----
// Sequencing controller of the multi-turn angle tracker.
// Walks one beat through turn update, multiplies and divisions; uses mat_pkg.
`default_nettype none

module mat_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mat_pkg::sts_t sts,
  output mat_pkg::cmd_t      cmd
);
  import mat_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_TURN;
      S_TURN:     state_nxt = S_PROD;
      S_PROD:     state_nxt = S_MOD_LD;
      S_MOD_LD:   state_nxt = S_MOD_RUN;
      S_MOD_RUN:  if (sts.div_last) state_nxt = S_EMUL_LO;
      S_EMUL_LO:  state_nxt = S_EMUL_HI;
      S_EMUL_HI:  state_nxt = S_EDIV_LD;
      S_EDIV_LD:  state_nxt = S_EDIV_RUN;
      S_EDIV_RUN: if (sts.div_last) state_nxt = S_ELEC_FIN;
      S_ELEC_FIN: state_nxt = S_MMUL_LO;
      S_MMUL_LO:  state_nxt = S_MMUL_HI;
      S_MMUL_HI:  state_nxt = S_MDIV_LD;
      S_MDIV_LD:  state_nxt = S_MDIV_RUN;
      S_MDIV_RUN: if (sts.div_last) state_nxt = S_DONE;
      S_DONE:     if (sts.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_TURN:     cmd.turn = 1'b1;
      S_PROD:     cmd.prod = 1'b1;
      S_MOD_LD: begin
        cmd.div_load = 1'b1;
        cmd.div_sel  = DSEL_MOD;
      end
      S_MOD_RUN:  cmd.div_step = 1'b1;
      S_EMUL_LO: begin
        cmd.mul_lo  = 1'b1;
        cmd.mul_src = MSRC_ELEC;
      end
      S_EMUL_HI: begin
        cmd.mul_hi  = 1'b1;
        cmd.mul_src = MSRC_ELEC;
      end
      S_EDIV_LD: begin
        cmd.div_load = 1'b1;
        cmd.div_sel  = DSEL_ELEC;
      end
      S_EDIV_RUN: cmd.div_step = 1'b1;
      S_ELEC_FIN: cmd.elec_fin = 1'b1;
      S_MMUL_LO: begin
        cmd.mul_lo  = 1'b1;
        cmd.mul_src = MSRC_MECH;
      end
      S_MMUL_HI: begin
        cmd.mul_hi  = 1'b1;
        cmd.mul_src = MSRC_MECH;
      end
      S_MDIV_LD: begin
        cmd.div_load = 1'b1;
        cmd.div_sel  = DSEL_MECH;
      end
      S_MDIV_RUN: cmd.div_step = 1'b1;
      S_DONE:     cmd.out_load = sts.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/mat_dp.sv -----
// Datapath of the multi-turn angle tracker: configuration and turn state,
// a split multiplier, a shared radix-4 divider and the result register.
// Driven by mat_ctrl through cmd_t; uses mat_pkg.
`default_nettype none

module mat_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire mat_pkg::cmd_t                       cmd,
  output mat_pkg::sts_t                            sts,
  input  wire logic                                in_kind,
  input  wire logic [mat_pkg::WORD_BITS-1:0]       in_spi_word,
  input  wire logic                                cfg_we,
  input  wire logic [mat_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [mat_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic signed [mat_pkg::MECH_BITS-1:0]     out_mech_angle,
  output logic [mat_pkg::ELEC_BITS-1:0]            out_elec_angle,
  output logic signed [mat_pkg::TURN_BITS-1:0]     out_turns
);
  import mat_pkg::*;

  localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

  // Configuration registers.
  logic [CPR_BITS-1:0]    cpr_r;
  logic [POLE_BITS-1:0]   pole_r;
  logic [OFFSET_BITS-1:0] offset_r;
  logic [CPR_BITS-1:0]    cpr_eff;

  // Tracking state and per-beat registers.
  logic signed [TURN_BITS-1:0] turn_r;
  logic signed [TURN_BITS-1:0] turn_nxt;
  logic [COUNT_BITS-1:0]       last_r;
  logic [COUNT_BITS-1:0]       count_r;
  logic                        kind_r;
  logic signed [NUM_BITS-1:0]  num_r;
  logic signed [NUM_BITS-1:0]  num_nxt;
  logic signed [NUM_BITS-1:0]  cpr_turns;
  logic [PPC_BITS-1:0]         ppc_r;
  logic [PPC_BITS-1:0]         ppc_nxt;

  // Multiplier and accumulator.
  logic [ACC_BITS-1:0]  acc_r;
  logic [ACC_BITS-1:0]  acc_nxt;
  logic [MAG_BITS-1:0]  mul_a;
  logic [KLO_BITS-1:0]  mul_k;
  logic [PROD_BITS-1:0] mul_p;
  logic [NUM_BITS-1:0]  mag_full;
  logic                 num_neg;

  // Divider.
  logic [CPR_BITS-1:0] rem_r;
  logic [CPR_BITS-1:0] rem_nxt;
  logic [DVD_BITS-1:0] dvd_r;
  logic [DVD_BITS-1:0] dvd_nxt;
  logic [QUO_BITS-1:0] quo_r;
  logic [QUO_BITS-1:0] quo_nxt;
  logic [CNT_BITS-1:0] step_r;
  logic [CNT_BITS-1:0] step_nxt;
  logic [CPR_BITS:0]   div_t1;
  logic [CPR_BITS:0]   div_r1;
  logic [CPR_BITS:0]   div_t2;
  logic [CPR_BITS:0]   div_r2;
  logic                div_q1;
  logic                div_q2;

  // Electrical angle and result.
  logic [ELEC_BITS-1:0]         elec_r;
  logic [ELEC_BITS-1:0]         elec_nxt;
  logic signed [ELEC_BITS+1:0]  elec_diff;
  logic signed [ELEC_BITS+1:0]  elec_wrap;
  logic signed [MECH_BITS-1:0]  mech_val;
  logic                         out_valid_r;

  // Turn detection.
  logic signed [COUNT_BITS+1:0] delta;
  logic signed [COUNT_BITS+1:0] quarter;
  logic signed [TURN_BITS-1:0]  turn_base;

  assign cpr_eff = (cpr_r == '0) ? {{(CPR_BITS-1){1'b0}}, 1'b1} : cpr_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r    <= CPR_BITS'(4096);
      pole_r   <= POLE_BITS'(1);
      offset_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CPR:    cpr_r    <= cfg_data[CPR_BITS-1:0];
        CFG_POLE:   pole_r   <= cfg_data[POLE_BITS-1:0];
        CFG_OFFSET: offset_r <= cfg_data[OFFSET_BITS-1:0];
        default:    ;
      endcase
    end
  end

  // Turn update: a jump beyond a quarter turn counts a wrap, saturating; kind 1 clears first.
  always_comb begin
    delta     = $signed({2'b00, count_r}) - $signed({2'b00, last_r});
    quarter   = $signed({3'b000, cpr_eff[CPR_BITS-1:2]});
    turn_base = kind_r ? '0 : turn_r;
    turn_nxt  = turn_base;
    if (delta > quarter) begin
      if (turn_base != TURN_MIN) turn_nxt = turn_base - TURN_BITS'(1);
    end else if (delta < -quarter) begin
      if (turn_base != TURN_MAX) turn_nxt = turn_base + TURN_BITS'(1);
    end
  end

  // Numerators of the two angles.
  assign cpr_turns = $signed({1'b0, cpr_eff}) * turn_r;
  assign num_nxt   = cpr_turns + $signed({{(NUM_BITS-COUNT_BITS){1'b0}}, count_r});
  assign ppc_nxt   = PPC_BITS'(pole_r) * PPC_BITS'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_r <= '0;
      last_r <= '0;
    end else if (cmd.turn) begin
      turn_r <= turn_nxt;
      last_r <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_kind;
      count_r <= in_spi_word[WORD_BITS-1 -: COUNT_BITS];
    end
    if (cmd.prod) begin
      num_r <= num_nxt;
      ppc_r <= ppc_nxt;
    end
  end

  // Multiply by 2*pi in two partial products; the first adds the rounding half.
  assign num_neg  = num_r[NUM_BITS-1];
  assign mag_full = num_neg ? NUM_BITS'(-num_r) : NUM_BITS'(num_r);
  assign mul_a    = (cmd.mul_src == MSRC_ELEC) ? MAG_BITS'(rem_r) : mag_full[MAG_BITS-1:0];
  assign mul_k    = cmd.mul_hi ? KLO_BITS'(PI2_K_HI) : PI2_K_LO;
  assign mul_p    = PROD_BITS'(mul_a) * PROD_BITS'(mul_k);

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.mul_lo) begin
      acc_nxt = ACC_BITS'(mul_p) + (ACC_BITS'(cpr_eff) << (FRAC_BITS - 1));
    end else if (cmd.mul_hi) begin
      acc_nxt = acc_r + (ACC_BITS'(mul_p) << KLO_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_lo || cmd.mul_hi) acc_r <= acc_nxt;
  end

  // Shared restoring divider by cpr, two quotient bits per step.
  always_comb begin
    div_t1 = {rem_r, dvd_r[DVD_BITS-1]};
    div_q1 = (div_t1 >= {1'b0, cpr_eff});
    div_r1 = div_q1 ? (div_t1 - {1'b0, cpr_eff}) : div_t1;
    div_t2 = {div_r1[CPR_BITS-1:0], dvd_r[DVD_BITS-2]};
    div_q2 = (div_t2 >= {1'b0, cpr_eff});
    div_r2 = div_q2 ? (div_t2 - {1'b0, cpr_eff}) : div_t2;
  end

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    if (cmd.div_load) begin
      quo_nxt = '0;
      unique case (cmd.div_sel)
        DSEL_MOD: begin
          rem_nxt  = '0;
          dvd_nxt  = {QW_MOD'(ppc_r), {(DVD_BITS-QW_MOD){1'b0}}};
          step_nxt = CNT_BITS'(QW_MOD/2 - 1);
        end
        DSEL_ELEC: begin
          rem_nxt  = acc_r[FRAC_BITS+QW_ELEC +: CPR_BITS];
          dvd_nxt  = {acc_r[FRAC_BITS +: QW_ELEC], {(DVD_BITS-QW_ELEC){1'b0}}};
          step_nxt = CNT_BITS'(QW_ELEC/2 - 1);
        end
        DSEL_MECH: begin
          rem_nxt  = acc_r[FRAC_BITS+QW_MECH +: CPR_BITS];
          dvd_nxt  = {acc_r[FRAC_BITS +: QW_MECH], {(DVD_BITS-QW_MECH){1'b0}}};
          step_nxt = CNT_BITS'(QW_MECH/2 - 1);
        end
        default: begin
          rem_nxt  = '0;
          dvd_nxt  = '0;
          step_nxt = '0;
        end
      endcase
    end else if (cmd.div_step) begin
      rem_nxt  = div_r2[CPR_BITS-1:0];
      dvd_nxt  = dvd_r << 2;
      quo_nxt  = {quo_r[QUO_BITS-3:0], div_q1, div_q2};
      step_nxt = step_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load || cmd.div_step) begin
      rem_r  <= rem_nxt;
      dvd_r  <= dvd_nxt;
      quo_r  <= quo_nxt;
      step_r <= step_nxt;
    end
  end

  assign sts.div_last = (step_r == '0);

  // Electrical angle: subtract the offset, wrap once by 2*pi, clamp at zero.
  always_comb begin
    elec_diff = $signed({2'b00, quo_r[ELEC_BITS-1:0]}) - $signed({2'b00, offset_r});
    elec_wrap = elec_diff + $signed({2'b00, PI2_QF});
    if (elec_diff >= 0) begin
      elec_nxt = elec_diff[ELEC_BITS-1:0];
    end else if (elec_wrap >= 0) begin
      elec_nxt = elec_wrap[ELEC_BITS-1:0];
    end else begin
      elec_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.elec_fin) elec_r <= elec_nxt;
  end

  // Result register: frees the core while the receiver stalls.
  assign mech_val     = num_neg ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_mech_angle <= mech_val;
      out_elec_angle <= elec_r;
      out_turns      <= turn_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  // The partial remainder stays below the divisor through every step.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < cpr_eff))
    else $error("divider remainder not below counts per rev");

  // Without a clear, the turn count moves by at most one per beat.
  a_turn_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.turn && !kind_r) |=> ((turn_r == $past(turn_r)) ||
                               (turn_r == $past(turn_r) + TURN_BITS'(1)) ||
                               (turn_r == $past(turn_r) - TURN_BITS'(1))))
    else $error("turn count jumped by more than one");

  // The electrical angle never reaches past a full turn.
  a_elec_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.elec_fin |=> (elec_r <= PI2_QF))
    else $error("electrical angle out of range");

  // A result is never loaded over one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

// ----- sv/multiturn_angle_tracker_core.sv -----
// Multi-turn angle tracker: top level joining the controller and datapath.
// Depends on mat_pkg, mat_if, mat_ctrl and mat_dp.
//
// Usage:
//   in_ch carries one beat per sensor word: kind (1 clears the turn count
//   first) and the raw 16-bit spi_word whose bits 15..4 are the angle count.
//   out_ch returns one beat per input beat: the multi-turn mechanical angle,
//   the electrical angle in [0, 2*pi) and the turn count, angles in Q.16
//   radians. cfg_we/cfg_index/cfg_data write counts_per_rev (0), pole_pairs
//   (1) and elec_offset (2); write only while no beat is in flight.
//   A new input beat is taken only after the previous one has been loaded
//   into the result register. Each beat runs the shared radix-4 divider
//   in 10 steps for the pole-pair remainder, 10 for the electrical angle
//   and 17 for the mechanical angle, besides the multiplies and bookkeeping.
//   A stalled receiver holds the result register; the next input beat is
//   still taken and processed, and waits for the register to free.
//   Reset (synchronous, rst_n low) zeroes the turn count and last count and
//   restores counts_per_rev = 4096, pole_pairs = 1, elec_offset = 0.
`default_nettype none

module multiturn_angle_tracker_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  mat_in_if.sink                                  in_ch,
  mat_out_if.source                               out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [mat_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [mat_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import mat_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // Sequencer.
  mat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic and state.
  mat_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_ch.kind),
    .in_spi_word    (in_ch.spi_word),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_mech_angle (out_ch.mech_angle),
    .out_elec_angle (out_ch.elec_angle),
    .out_turns      (out_ch.turns)
  );

  assign in_ch.ready = in_ready;

endmodule

`default_nettype wire
